[hdl/mrfp_pkg.sv]
// Shared types and constants for the motor report frame parser.
// No dependencies; imported by the parser core, the top level and the checker.
package mrfp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] KIND_ALL = 2'd0;
  localparam logic [1:0] KIND_TEP = 2'd1;
  localparam logic [1:0] KIND_SPD = 2'd2;

  typedef struct packed {
    logic       start;
    logic       feed;
    logic [7:0] data;
  } parse_cmd_t;

  typedef struct packed {
    logic             ok;
    logic [3:0][15:0] values;
  } parse_res_t;

endpackage

[hdl/mrfp_field_parser.sv]
// Number parser for the text after a report prefix: four comma-separated integers.
// Depends on mrfp_pkg for the byte codes and the command and result structs.
module mrfp_field_parser import mrfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  parse_cmd_t cmd,
  output parse_res_t res
);

  typedef enum logic [2:0] {
    PH_BEFORE,
    PH_SIGN,
    PH_DIGITS,
    PH_AFTER,
    PH_DONE,
    PH_FAIL
  } phase_t;

  localparam logic [31:0] MagCap = 32'h8000_0000;

  phase_t           phase, phase_next;
  logic [1:0]       index, index_next;
  logic             negative, negative_next;
  logic [31:0]      magnitude, magnitude_next;
  logic [3:0][15:0] values;

  logic        is_digit, is_wide, is_narrow, is_comma, is_sign;
  logic [34:0] grown;
  logic [31:0] sat_mag;
  logic [15:0] commit_val;
  logic        commit;
  logic        finishing;

  always_comb begin
    is_digit  = (cmd.data >= CH_ZERO) && (cmd.data <= CH_NINE);
    is_narrow = (cmd.data == CH_SPACE) || (cmd.data == CH_TAB) ||
                (cmd.data == CH_LF) || (cmd.data == CH_CR);
    is_wide   = (cmd.data == CH_SPACE) || ((cmd.data >= CH_TAB) && (cmd.data <= CH_CR));
    is_comma  = cmd.data == CH_COMMA;
    is_sign   = (cmd.data == CH_PLUS) || (cmd.data == CH_MINUS);
    grown     = 35'({magnitude, 3'b000}) + 35'({magnitude, 1'b0}) + 35'(cmd.data[3:0]);
    sat_mag   = (grown > 35'(MagCap)) ? MagCap : grown[31:0];
    if (negative) begin
      commit_val = 16'd0 - magnitude[15:0];
    end else begin
      commit_val = magnitude[31] ? 16'hFFFF : magnitude[15:0];
    end
  end

  always_comb begin
    phase_next     = phase;
    index_next     = index;
    negative_next  = negative;
    magnitude_next = magnitude;
    commit         = 1'b0;
    case (phase)
      PH_BEFORE: begin
        if (is_wide) begin
        end else if (is_sign) begin
          negative_next = cmd.data == CH_MINUS;
          phase_next    = PH_SIGN;
        end else if (is_digit) begin
          magnitude_next = sat_mag;
          phase_next     = PH_DIGITS;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          magnitude_next = sat_mag;
          phase_next     = PH_DIGITS;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          magnitude_next = sat_mag;
        end else if (index == 2'd3) begin
          commit     = 1'b1;
          phase_next = PH_DONE;
        end else if (is_comma) begin
          commit     = 1'b1;
          index_next = index + 2'd1;
          phase_next = PH_BEFORE;
        end else if (is_narrow) begin
          commit     = 1'b1;
          phase_next = PH_AFTER;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_AFTER: begin
        if (is_narrow) begin
        end else if (is_comma) begin
          index_next = index + 2'd1;
          phase_next = PH_BEFORE;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      default: begin
      end
    endcase
    if (commit) begin
      negative_next  = 1'b0;
      magnitude_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      phase     <= PH_BEFORE;
      index     <= '0;
      negative  <= 1'b0;
      magnitude <= '0;
      values    <= '0;
    end else if (cmd.feed) begin
      phase     <= phase_next;
      index     <= index_next;
      negative  <= negative_next;
      magnitude <= magnitude_next;
      if (commit) begin
        values[index] <= commit_val;
      end
    end
  end

  // A fourth number still in its digits is complete when the frame closes.
  always_comb begin
    finishing  = (phase == PH_DIGITS) && (index == 2'd3);
    res.ok     = (phase == PH_DONE) || finishing;
    res.values = values;
    if (finishing) begin
      res.values[3] = commit_val;
    end
  end

endmodule

[hdl/motor_report_frame_parser_top.sv]
// Top level of the motor report frame parser: framing, prefix match and result register.
// Depends on mrfp_pkg and mrfp_field_parser.
//
// Bytes enter at one per cycle with no gaps required. Each byte is held in an input
// register and is then folded into the frame state by a single combinational pass, so a
// report appears on the result port, from the result register, once its closing '#' has
// left the input register. While a result waits untaken, one more byte can enter the input
// register; the input then stalls until the result is taken.
module motor_report_frame_parser_top import mrfp_pkg::*; #(
  parameter int FRAME_BUFFER_LEN = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         packet_kind,
  output logic               values_ok,
  output logic signed [15:0] wheel_one_value,
  output logic signed [15:0] wheel_two_value,
  output logic signed [15:0] wheel_three_value,
  output logic signed [15:0] wheel_four_value,
  output logic [31:0]        frames_accepted
);

  localparam int LenW = $clog2(FRAME_BUFFER_LEN);

  logic            byte_valid;
  logic [7:0]      byte_q;
  logic            open;
  logic [LenW-1:0] length;
  logic [2:0]      mask, mask_next;
  logic            terminated;
  logic [31:0]     count;

  logic       advance, step, is_hash, in_prefix, overlong, report;
  logic [1:0] kind;
  logic       ok;
  parse_cmd_t cmd;
  parse_res_t res;

  function automatic logic [7:0] prefix_char(input logic [1:0] which, input logic [2:0] pos);
    logic [4:0][7:0] text;
    case (which)
      2'd0:    text = {":", "l", "l", "A", "M"};
      2'd1:    text = {":", "P", "E", "T", "M"};
      default: text = {":", "D", "P", "S", "M"};
    endcase
    prefix_char = (pos <= 3'd4) ? text[pos] : CH_NUL;
  endfunction

  always_comb begin
    advance   = !out_valid || out_ready;
    in_ready  = !byte_valid || advance;
    step      = byte_valid && advance;
    is_hash   = byte_q == CH_HASH;
    in_prefix = length < LenW'(5);
    overlong  = length >= LenW'(FRAME_BUFFER_LEN - 1);
    for (int i = 0; i < 3; i++) begin
      mask_next[i] = mask[i] && (prefix_char(2'(i), length[2:0]) == byte_q);
    end
    report = open && is_hash && !in_prefix && (mask != 3'b000);
    if (mask[0]) begin
      kind = KIND_ALL;
    end else if (mask[1]) begin
      kind = KIND_TEP;
    end else begin
      kind = KIND_SPD;
    end
    ok        = (kind != KIND_SPD) && res.ok;
    cmd.start = step && !open && (byte_q == CH_DOLLAR);
    cmd.feed  = step && open && !is_hash && !overlong && !in_prefix && !terminated &&
                (byte_q != CH_NUL);
    cmd.data  = byte_q;
  end

  mrfp_field_parser u_parser (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      open       <= 1'b0;
      length     <= '0;
      mask       <= 3'b111;
      terminated <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        byte_valid <= 1'b1;
        byte_q     <= rx_byte;
      end else if (step) begin
        byte_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= step && report;
      end
      if (step) begin
        if (!open) begin
          if (byte_q == CH_DOLLAR) begin
            open       <= 1'b1;
            length     <= '0;
            mask       <= 3'b111;
            terminated <= 1'b0;
          end
        end else if (is_hash || overlong) begin
          open   <= 1'b0;
          length <= '0;
          if (report) begin
            count             <= count + 32'd1;
            packet_kind       <= kind;
            values_ok         <= ok;
            wheel_one_value   <= ok ? $signed(res.values[0]) : 16'sd0;
            wheel_two_value   <= ok ? $signed(res.values[1]) : 16'sd0;
            wheel_three_value <= ok ? $signed(res.values[2]) : 16'sd0;
            wheel_four_value  <= ok ? $signed(res.values[3]) : 16'sd0;
            frames_accepted   <= count + 32'd1;
          end
        end else begin
          length <= length + LenW'(1);
          if (in_prefix) begin
            mask <= mask_next;
          end
          if (byte_q == CH_NUL) begin
            terminated <= 1'b1;
          end
        end
      end
    end
  end

endmodule

[hdl/mrfp_checker.sv]
// Port-level checks for the motor report frame parser, bound to the top level.
// Depends on mrfp_pkg for the report kind codes.
module mrfp_checker import mrfp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         packet_kind,
  input logic               values_ok,
  input logic signed [15:0] wheel_one_value,
  input logic signed [15:0] wheel_two_value,
  input logic signed [15:0] wheel_three_value,
  input logic signed [15:0] wheel_four_value,
  input logic [31:0]        frames_accepted
);

  logic [31:0] expected;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= 32'd1;
    end else if (out_valid && out_ready) begin
      expected <= frames_accepted + 32'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frames_accepted) && $stable(packet_kind))
    else $error("Result word changed while stalled.");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frames_accepted == expected)
    else $error("Frame count did not advance by one per report.");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_kind == KIND_ALL || packet_kind == KIND_TEP ||
                  packet_kind == KIND_SPD)
    else $error("Unknown report kind.");

  a_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_kind == KIND_SPD |-> !values_ok)
    else $error("Speed report flagged with parsed values.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !values_ok |-> wheel_one_value == 16'sd0 && wheel_two_value == 16'sd0 &&
                                wheel_three_value == 16'sd0 && wheel_four_value == 16'sd0)
    else $error("Wheel values not cleared on a failed parse.");

endmodule

bind motor_report_frame_parser_top mrfp_checker u_mrfp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .packet_kind       (packet_kind),
  .values_ok         (values_ok),
  .wheel_one_value   (wheel_one_value),
  .wheel_two_value   (wheel_two_value),
  .wheel_three_value (wheel_three_value),
  .wheel_four_value  (wheel_four_value),
  .frames_accepted   (frames_accepted)
);
